@@ hw/rtl/humidity_temp_frame_decoder_core_macros.svh @@
// assertion macros for the frame decoder checker
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_MACROS_SVH

// same-cycle implication, ignored while in reset
`define HTFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored while in reset
`define HTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers the reset cycles
`define HTFD_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/htfd_pkg.sv @@
// shared types, constants and crc function of the frame decoder
`default_nettype none
package htfd_pkg;

  localparam logic [7:0]  CRC_POLY = 8'h31;
  localparam logic [7:0]  CRC_INIT = 8'hFF;

  localparam logic [14:0] T_SCALE  = 15'd26703;
  localparam logic [13:0] H_SCALE  = 14'd15259;
  localparam logic [14:0] T_OFFSET = 15'd4500;

  // floor(x / 100000) = floor(floor(x / 32) / 3125)
  // floor(y / 3125) = (y * RECIP) >> RECIP_SHIFT, exact for y < 2**26
  localparam int          PRE_SHIFT   = 5;
  localparam logic [26:0] RECIP       = 27'd87960931;
  localparam int          RECIP_SHIFT = 38;

  typedef struct packed {
    logic        valid;
    logic        ok;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } htfd_evt_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/htfd_frame.sv @@
// byte position tracking, word crc checks and held raw values
`default_nettype none
module htfd_frame
  import htfd_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire  [7:0] data_byte,
  input  wire        frame_start,
  output htfd_evt_t  evt
);

  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;
  localparam logic [2:0] POS_IDLE  = 3'd6;

  logic [2:0]  pos_r, pos_nxt, pos;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] word_r, word_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic        first_ok_r, first_ok_nxt;
  logic [15:0] temp_held_r, temp_held_nxt;
  logic [15:0] hum_held_r, hum_held_nxt;
  logic        accept;
  logic        frame_ok;

  assign accept = in_valid & in_ready;

  always_comb begin
    pos           = frame_start ? POS_T_MSB : pos_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    word_nxt      = word_r;
    pend_nxt      = pend_r;
    first_ok_nxt  = first_ok_r;
    temp_held_nxt = temp_held_r;
    hum_held_nxt  = hum_held_r;
    frame_ok      = first_ok_r && (crc_r == data_byte);
    evt.valid     = 1'b0;
    evt.ok        = frame_ok;
    evt.temp_raw  = frame_ok ? pend_r : temp_held_r;
    evt.hum_raw   = frame_ok ? word_r : hum_held_r;
    if (accept) begin
      pos_nxt = pos;
      unique case (pos)
        POS_T_MSB, POS_H_MSB: begin
          crc_nxt  = crc8_update(CRC_INIT, data_byte);
          word_nxt = {data_byte, 8'h00};
          pos_nxt  = pos + 3'd1;
        end
        POS_T_LSB, POS_H_LSB: begin
          crc_nxt  = crc8_update(crc_r, data_byte);
          word_nxt = word_r | {8'h00, data_byte};
          pos_nxt  = pos + 3'd1;
        end
        POS_T_CRC: begin
          first_ok_nxt = (crc_r == data_byte);
          pend_nxt     = word_r;
          pos_nxt      = pos + 3'd1;
        end
        POS_H_CRC: begin
          if (frame_ok) begin
            temp_held_nxt = pend_r;
            hum_held_nxt  = word_r;
          end
          pos_nxt   = POS_IDLE;
          evt.valid = 1'b1;
        end
        default: begin
          pos_nxt = pos;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_IDLE;
      crc_r       <= CRC_INIT;
      word_r      <= 16'h0000;
      pend_r      <= 16'h0000;
      first_ok_r  <= 1'b0;
      temp_held_r <= 16'h0000;
      hum_held_r  <= 16'h0000;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      word_r      <= word_nxt;
      pend_r      <= pend_nxt;
      first_ok_r  <= first_ok_nxt;
      temp_held_r <= temp_held_nxt;
      hum_held_r  <= hum_held_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/htfd_scale.sv @@
// three-stage scaling pipeline: gain multiply, divide by 100000, offset and output register
`default_nettype none
module htfd_scale
  import htfd_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire  htfd_evt_t    evt,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               out_ok,
  output logic signed [14:0] out_temp,
  output logic        [13:0] out_hum
);

  logic        rdy1, rdy2, rdy3;

  logic        v1_r, v1_nxt;
  logic        ok1_r;
  logic [30:0] tp1_r, tp1_nxt;
  logic [29:0] hp1_r, hp1_nxt;

  logic        v2_r, v2_nxt;
  logic        ok2_r;
  logic [52:0] tprod;
  logic [51:0] hprod;
  logic [14:0] tq2_r;
  logic [13:0] hq2_r;

  logic        v3_r, v3_nxt;
  logic        ok3_r;
  logic [14:0] temp3_r;
  logic [13:0] hum3_r;

  assign rdy3     = !v3_r | out_ready;
  assign rdy2     = !v2_r | rdy3;
  assign rdy1     = !v1_r | rdy2;
  assign in_ready = rdy1;

  assign v1_nxt = rdy1 ? evt.valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;

  assign tp1_nxt = {15'd0, evt.temp_raw} * {16'd0, T_SCALE};
  assign hp1_nxt = {14'd0, evt.hum_raw} * {16'd0, H_SCALE};

  assign tprod = {27'd0, tp1_r[30:PRE_SHIFT]} * {26'd0, RECIP};
  assign hprod = {27'd0, hp1_r[29:PRE_SHIFT]} * {25'd0, RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 & evt.valid) begin
      ok1_r <= evt.ok;
      tp1_r <= tp1_nxt;
      hp1_r <= hp1_nxt;
    end
    if (rdy2 & v1_r) begin
      ok2_r <= ok1_r;
      tq2_r <= tprod[RECIP_SHIFT+14:RECIP_SHIFT];
      hq2_r <= hprod[RECIP_SHIFT+13:RECIP_SHIFT];
    end
    if (rdy3 & v2_r) begin
      ok3_r   <= ok2_r;
      temp3_r <= tq2_r - T_OFFSET;
      hum3_r  <= hq2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_ok    = ok3_r;
  assign out_temp  = $signed(temp3_r);
  assign out_hum   = hum3_r;

endmodule
`default_nettype wire

@@ hw/rtl/humidity_temp_frame_decoder_core.sv @@
// top level of the humidity and temperature frame decoder
// usage:
//   in channel: one frame byte per transaction; in_tuser high marks the first
//   byte of a six-byte frame (temp msb, lsb, crc, humidity msb, lsb, crc)
//   out channel: one transaction per complete frame, on its sixth byte
//   out_tuser is the frame_ok flag (both crc-8 words matched)
//   result path: the frame tracker raises the event as the sixth byte is taken,
//   then gain multiply stage, divide stage and output register lead to out_tvalid
//   throughput: one input byte per cycle; in_tready is low only when the
//   scaling pipeline is full and the receiver holds out_tready low
//   a failed frame reports the previously held values with frame_ok low
//   bytes outside a frame are dropped without a result
//   reset: byte tracker goes idle until a first-byte flag, held raw values
//   read as zero, pipeline is emptied
//   receiver stall: the output register holds its transaction steady while
//   earlier stages keep filling
`default_nettype none
module humidity_temp_frame_decoder_core
  import htfd_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [14:0] temp_centi, [28:15] humidity_centi, [31:29] zero
  output logic        out_tuser   // [0] frame_ok
);

  htfd_evt_t          evt;
  logic signed [14:0] temp_centi;
  logic        [13:0] humidity_centi;

  htfd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .data_byte   (in_tdata),
    .frame_start (in_tuser),
    .evt         (evt)
  );

  htfd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt       (evt),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ok    (out_tuser),
    .out_temp  (temp_centi),
    .out_hum   (humidity_centi)
  );

  assign out_tdata = {3'b000, humidity_centi, temp_centi};

endmodule
`default_nettype wire

@@ hw/rtl/htfd_checker.sv @@
// port-level checker for the frame decoder and its bind
`default_nettype none
`include "humidity_temp_frame_decoder_core_macros.svh"
module htfd_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [7:0]  in_tdata,
  input wire        in_tuser,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire        out_tuser
);

  `HTFD_ASSERT_RST(a_rst_empty, !rst_n, !out_tvalid, "output valid right after reset")
  `HTFD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `HTFD_ASSERT_IMP(a_temp_range, out_tvalid, (!out_tdata[14] && out_tdata[14:0] <= 15'd12999) || (out_tdata[14] && out_tdata[14:0] >= 15'd28268), "temperature out of range")
  `HTFD_ASSERT_IMP(a_hum_range, out_tvalid, out_tdata[28:15] <= 14'd9999 && out_tdata[31:29] == 3'b000, "humidity out of range or pad bits set")

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (.*);
`default_nettype wire
